@@ hw/rtl/lsac_pkg.sv @@
`timescale 1ns / 1ps

package lsac_pkg;

	localparam int MAX_SET_BITS = 5;
	localparam int MAX_WAYS     = 8;
	localparam int ADDR_BITS    = 48;

	localparam int NUM_SETS = 1 << MAX_SET_BITS;
	localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int NW_W     = $clog2(MAX_WAYS + 1);
	localparam int TAG_W    = ADDR_BITS;
	localparam int CNT_W    = 32;

	localparam int SB_W       = 3;
	localparam int NWR_W      = 4;
	localparam int OFF_W      = 6;
	localparam int SHIFT_W    = OFF_W + 1;
	localparam int CFG_DATA_W = 6;
	localparam int CFG_IDX_W  = 2;

	localparam int REQ_W      = 2;
	localparam int IN_DATA_W  = ((ADDR_BITS + 7) / 8) * 8;
	localparam int OUT_BITS   = 3 + 3 * CNT_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD   = 2'd0,
		REQ_STORE  = 2'd1,
		REQ_MODIFY = 2'd2,
		REQ_IFETCH = 2'd3
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SET_BITS = 2'd0,
		CFG_WAYS     = 2'd1,
		CFG_OFFSET   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [SB_W-1:0]  sb;
		logic [OFF_W-1:0] off;
		logic [NW_W-1:0]  nw;
	} cfg_t;

	typedef struct packed {
		logic [SET_W-1:0] set;
		logic [TAG_W-1:0] tag;
		logic             two;
	} acc_t;

	typedef struct packed {
		logic             hit;
		logic             miss;
		logic             eviction;
		logic             last;
		logic [CNT_W-1:0] hit_total;
		logic [CNT_W-1:0] miss_total;
		logic [CNT_W-1:0] eviction_total;
	} res_t;

	typedef logic [MAX_WAYS-1:0][TAG_W-1:0] tag_row_t;

endpackage

@@ hw/rtl/lsac_front.sv @@
`timescale 1ns / 1ps

module lsac_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lsac_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lsac_pkg::REQ_W-1:0]     in_req,
	input  logic [lsac_pkg::ADDR_BITS-1:0] in_addr,
	output logic                          push,
	output lsac_pkg::acc_t                push_data,
	input  logic                          full
);
	import lsac_pkg::*;

	logic                 valid_s1;
	logic [REQ_W-1:0]     req_s1;
	logic [ADDR_BITS-1:0] addr_s1;
	logic [SHIFT_W-1:0]   tag_shift;
	logic [ADDR_BITS-1:0] set_field;
	logic [SET_W-1:0]     set_ones;

	assign in_ready = !valid_s1 || !full;
	assign push     = valid_s1 && !full;

	// Instruction fetches are taken and dropped here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			req_s1   <= '0;
			addr_s1  <= '0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && (in_req != REQ_IFETCH);
			if (in_valid) begin
				req_s1  <= in_req;
				addr_s1 <= in_addr;
			end
		end
	end

	always_comb begin
		set_ones      = '1;
		tag_shift     = SHIFT_W'(cfg.off) + SHIFT_W'(cfg.sb);
		set_field     = addr_s1 >> cfg.off;
		push_data.set = set_field[SET_W-1:0] & ~(set_ones << cfg.sb);
		push_data.tag = addr_s1 >> tag_shift;
		push_data.two = (req_s1 == REQ_MODIFY);
	end

endmodule

@@ hw/rtl/lsac_fifo.sv @@
`timescale 1ns / 1ps

module lsac_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lsac_pkg::acc_t push_data,
	output logic           full,
	input  logic           pop,
	output lsac_pkg::acc_t pop_data,
	output logic           not_empty
);
	import lsac_pkg::*;

	acc_t                  slot_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q;
	logic [FIFO_PTR_W-1:0] rd_q;
	logic [FIFO_CNT_W-1:0] cnt_q;

	assign full      = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

endmodule

@@ hw/rtl/lsac_back.sv @@
`timescale 1ns / 1ps

module lsac_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [lsac_pkg::NW_W-1:0] nw,
	input  logic                     acc_valid,
	output logic                     acc_pop,
	input  lsac_pkg::acc_t           acc,
	output logic                     out_valid,
	input  logic                     out_ready,
	output lsac_pkg::res_t           out_res
);
	import lsac_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_COMP,
		ST_WRITE
	} state_t;

	state_t                          state_q;
	logic [SET_W-1:0]                set_q;
	logic [TAG_W-1:0]                tag_q;
	logic                            two_q;
	logic                            last_q;
	logic [WAY_W-1:0]                way_q;
	logic                            hit_q;
	logic                            evict_q;
	logic [CNT_W-1:0]                hcnt_q;
	logic [CNT_W-1:0]                mcnt_q;
	logic [CNT_W-1:0]                ecnt_q;
	logic                            out_valid_q;
	res_t                            out_res_q;
	logic [NUM_SETS-1:0][MAX_WAYS-1:0] valid_q;

	tag_row_t tag_mem [NUM_SETS];
	tag_row_t row_q;

	logic [MAX_WAYS-1:0] vrow;
	logic [MAX_WAYS-1:0] match;
	logic [MAX_WAYS-1:0] free;
	logic [WAY_W-1:0]    match_way;
	logic [WAY_W-1:0]    free_way;
	logic [WAY_W-1:0]    way_c;
	logic                evict_c;
	tag_row_t            new_row;
	logic [MAX_WAYS-1:0] new_vrow;
	logic                out_free;
	logic                wr_en;
	logic [CNT_W-1:0]    hcnt_next;
	logic [CNT_W-1:0]    mcnt_next;
	logic [CNT_W-1:0]    ecnt_next;

	assign out_free  = !out_valid_q || out_ready;
	assign wr_en     = (state_q == ST_WRITE) && out_free;
	assign acc_pop   = (state_q == ST_IDLE) && acc_valid;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;
	assign vrow      = valid_q[set_q];

	assign hcnt_next = hcnt_q + CNT_W'(hit_q);
	assign mcnt_next = mcnt_q + CNT_W'(!hit_q);
	assign ecnt_next = ecnt_q + CNT_W'(evict_q);

	// Way lookup: first matching valid way, else first empty way, else the LRU way.
	always_comb begin
		match_way = '0;
		free_way  = '0;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			match[i] = (NW_W'(i) < nw) && vrow[i] && (row_q[i] == tag_q);
			free[i]  = (NW_W'(i) < nw) && !vrow[i];
			if (match[i]) begin
				match_way = WAY_W'(i);
			end
			if (free[i]) begin
				free_way = WAY_W'(i);
			end
		end
		evict_c = !(|match) && !(|free);
		if (|match) begin
			way_c = match_way;
		end else if (|free) begin
			way_c = free_way;
		end else begin
			way_c = WAY_W'(nw - 1'b1);
		end
	end

	// The accessed way moves to the front; the ways ahead of it slide back by one.
	always_comb begin
		new_row     = row_q;
		new_vrow    = vrow;
		new_row[0]  = tag_q;
		new_vrow[0] = 1'b1;
		for (int i = 1; i < MAX_WAYS; i++) begin
			if (WAY_W'(i) <= way_q) begin
				new_row[i]  = row_q[i-1];
				new_vrow[i] = vrow[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			row_q <= tag_mem[set_q];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tag_mem[set_q] <= new_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			set_q       <= '0;
			tag_q       <= '0;
			two_q       <= 1'b0;
			last_q      <= 1'b0;
			way_q       <= '0;
			hit_q       <= 1'b0;
			evict_q     <= 1'b0;
			hcnt_q      <= '0;
			mcnt_q      <= '0;
			ecnt_q      <= '0;
			out_valid_q <= 1'b0;
			out_res_q   <= '0;
			valid_q     <= '0;
		end else begin
			if (out_ready && !wr_en) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc_valid) begin
						set_q   <= acc.set;
						tag_q   <= acc.tag;
						two_q   <= acc.two;
						last_q  <= !acc.two;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_COMP;
				end
				ST_COMP: begin
					way_q   <= way_c;
					hit_q   <= |match;
					evict_q <= evict_c;
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (out_free) begin
						valid_q[set_q]           <= new_vrow;
						hcnt_q                   <= hcnt_next;
						mcnt_q                   <= mcnt_next;
						ecnt_q                   <= ecnt_next;
						out_valid_q              <= 1'b1;
						out_res_q.hit            <= hit_q;
						out_res_q.miss           <= !hit_q;
						out_res_q.eviction       <= evict_q;
						out_res_q.last           <= last_q;
						out_res_q.hit_total      <= hcnt_next;
						out_res_q.miss_total     <= mcnt_next;
						out_res_q.eviction_total <= ecnt_next;
						if (two_q) begin
							two_q   <= 1'b0;
							last_q  <= 1'b1;
							state_q <= ST_READ;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/lru_set_assoc_cache_tags.sv @@
`timescale 1ns / 1ps

// Channel   Direction  tdata                                       tuser     tlast
// s_axis    in         address                                     req_type  -
// m_axis    out        hit, miss, eviction, hit_total, miss_total,  -         last
//                      eviction_total
// cfg       in         write enable, register index, write data
//
// An item that is taken is registered in the front end and then pushed into the queue.
// The back end pops it while idle and works through each access as set read, way compare,
// reorder and write back. A load or store is one access and a modify two to the same set.
// Reset clears all valid bits and counters at once; there is no clearing pass.
// A waiting result holds the back end in its write step, while the front end keeps taking
// items until the two-entry queue is full and its input register holds one more.

module lru_set_assoc_cache_tags (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// Fields from bit 0: address.
	input  logic [lsac_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// Fields from bit 0: req_type.
	input  logic [lsac_pkg::REQ_W-1:0]      s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// Fields from bit 0: hit, miss, eviction, hit_total, miss_total, eviction_total.
	output logic [lsac_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                            m_axis_tlast,
	input  logic                            cfg_we,
	input  logic [lsac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lsac_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lsac_pkg::*;

	logic [SB_W-1:0]  set_bits_q;
	logic [NWR_W-1:0] ways_q;
	logic [OFF_W-1:0] offset_q;
	cfg_t             cfg;
	logic             push;
	acc_t             push_data;
	logic             full;
	logic             pop;
	acc_t             pop_data;
	logic             not_empty;
	res_t             res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= '0;
			ways_q     <= NWR_W'(1);
			offset_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SET_BITS: set_bits_q <= cfg_data[SB_W-1:0];
				CFG_WAYS:     ways_q     <= cfg_data[NWR_W-1:0];
				CFG_OFFSET:   offset_q   <= cfg_data[OFF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.off = offset_q;
		cfg.sb  = (int'(set_bits_q) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS) : set_bits_q;
		if (ways_q == '0) begin
			cfg.nw = NW_W'(1);
		end else if (int'(ways_q) > MAX_WAYS) begin
			cfg.nw = NW_W'(MAX_WAYS);
		end else begin
			cfg.nw = NW_W'(ways_q);
		end
	end

	lsac_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_req    (s_axis_tuser),
		.in_addr   (s_axis_tdata[ADDR_BITS-1:0]),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	lsac_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (not_empty)
	);

	lsac_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.nw        (cfg.nw),
		.acc_valid (not_empty),
		.acc_pop   (pop),
		.acc       (pop_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tlast = res.last;
	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res.eviction_total, res.miss_total,
		res.hit_total, res.eviction, res.miss, res.hit};

endmodule

@@ hw/rtl/lsac_checker.sv @@
`timescale 1ns / 1ps

module lsac_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [lsac_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                            m_axis_tlast
);
	import lsac_pkg::*;

	logic             o_hit;
	logic             o_miss;
	logic             o_ev;
	logic [CNT_W-1:0] o_hcnt;
	logic [CNT_W-1:0] o_mcnt;
	logic [CNT_W-1:0] o_ecnt;
	logic [CNT_W-1:0] o_access;
	logic             take;
	logic             seen_q;
	logic [CNT_W-1:0] prev_access_q;
	logic [CNT_W-1:0] prev_ecnt_q;

	assign o_hit    = m_axis_tdata[0];
	assign o_miss   = m_axis_tdata[1];
	assign o_ev     = m_axis_tdata[2];
	assign o_hcnt   = m_axis_tdata[3 +: CNT_W];
	assign o_mcnt   = m_axis_tdata[3 + CNT_W +: CNT_W];
	assign o_ecnt   = m_axis_tdata[3 + 2 * CNT_W +: CNT_W];
	assign o_access = o_hcnt + o_mcnt;
	assign take     = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q        <= 1'b0;
			prev_access_q <= '0;
			prev_ecnt_q   <= '0;
		end else if (take) begin
			seen_q        <= 1'b1;
			prev_access_q <= o_access;
			prev_ecnt_q   <= o_ecnt;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (o_hit != o_miss) && (!o_ev || o_miss))
		else $error("inconsistent hit, miss and eviction flags");

	a_access_step: assert property (@(posedge clk) disable iff (!arst_n)
		take && seen_q |-> o_access == prev_access_q + CNT_W'(1))
		else $error("hit plus miss total did not advance by one");

	a_evict_step: assert property (@(posedge clk) disable iff (!arst_n)
		take && seen_q |-> o_ecnt == prev_ecnt_q + CNT_W'(o_ev))
		else $error("eviction total does not follow eviction flag");

endmodule

bind lru_set_assoc_cache_tags lsac_checker u_lsac_checker (.*);
